// ===== design/c65bs_pkg.sv =====
// Shared types for the 6502 bus stepper.
`timescale 1ns / 1ps
package c65bs_pkg;

    // Decode phase of the instruction in progress
    typedef enum logic [3:0] {
        PH_WAIT    = 4'd0,
        PH_OPCODE  = 4'd1,
        PH_OPLO    = 4'd2,
        PH_OPHI    = 4'd3,
        PH_PTRLO   = 4'd4,
        PH_PTRHI   = 4'd5,
        PH_OPERAND = 4'd6,
        PH_PULL1   = 4'd7,
        PH_PULL2   = 4'd8,
        PH_PULL3   = 4'd9,
        PH_VECLO   = 4'd10,
        PH_VECHI   = 4'd11
    } t_phase;

    // Address mode classes
    typedef enum logic [3:0] {
        M_NOP, M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX,
        M_ABSY, M_INDX, M_INDY, M_REL, M_BRK, M_JSR, M_PULL, M_PUSH
    } t_mode;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [7:0]  SP_RESET   = 8'hfd;
    localparam logic [15:0] VEC_BRK_LO = 16'hfffe;
    localparam logic [15:0] VEC_BRK_HI = 16'hffff;
    localparam logic [7:0]  STACK_PAGE = 8'h01;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  p;
        logic [7:0]  s;
        logic [15:0] pc;
    } t_regs;

    // One bus access
    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_acc;

    // All accesses caused by one request: writes first, read last
    typedef struct packed {
        logic [2:0]       cnt;
        t_acc [3:0]       acc;
    } t_step;

endpackage

// ===== design/c65bs_core.sv =====
// Processor state and combinational instruction step logic.
`timescale 1ns / 1ps
module c65bs_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_operation,
    input  logic [7:0]            i_read_data,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    output c65bs_pkg::t_step      o_step,
    output c65bs_pkg::t_regs      o_regs
);
    import c65bs_pkg::*;

    typedef struct packed {
        t_regs      rg;
        logic [7:0] r;
    } t_alu;

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        set_nz = (p & 8'h7d) | ((v == 8'h00) ? 8'h02 : 8'h00) | (v & 8'h80);
    endfunction

    function automatic logic documented(input logic [7:0] op);
        logic [1:0] cc;
        logic [2:0] bbb;
        logic [2:0] aaa;
        cc  = op[1:0];
        bbb = op[4:2];
        aaa = op[7:5];
        documented = 1'b1;
        if (cc == 2'd3) begin
            documented = 1'b0;
        end else if (cc == 2'd1) begin
            documented = (op != 8'h89);
        end else if (cc == 2'd2) begin
            case (bbb)
                3'd0:    documented = (op == 8'ha2);
                3'd4:    documented = 1'b0;
                3'd6:    documented = (op == 8'h9a) || (op == 8'hba);
                3'd7:    documented = (aaa != 3'd4);
                default: documented = 1'b1;
            endcase
        end else begin
            case (bbb)
                3'd0:    documented = (op != 8'h80);
                3'd1:    documented = (aaa == 3'd1) || aaa[2];
                3'd3:    documented = (aaa != 3'd0);
                3'd5:    documented = (aaa == 3'd4) || (aaa == 3'd5);
                3'd7:    documented = (aaa == 3'd5);
                default: documented = 1'b1;
            endcase
        end
    endfunction

    function automatic t_mode mode_of(input logic [7:0] op);
        logic [1:0] cc;
        logic [2:0] bbb;
        logic [2:0] aaa;
        cc  = op[1:0];
        bbb = op[4:2];
        aaa = op[7:5];
        mode_of = M_IMP;
        if (!documented(op)) begin
            mode_of = M_NOP;
        end else if (cc == 2'd1) begin
            unique case (bbb)
                3'd0: mode_of = M_INDX;
                3'd1: mode_of = M_ZP;
                3'd2: mode_of = M_IMM;
                3'd3: mode_of = M_ABS;
                3'd4: mode_of = M_INDY;
                3'd5: mode_of = M_ZPX;
                3'd6: mode_of = M_ABSY;
                3'd7: mode_of = M_ABSX;
                default: mode_of = M_NOP;
            endcase
        end else if (cc == 2'd2) begin
            case (bbb)
                3'd0:    mode_of = M_IMM;
                3'd1:    mode_of = M_ZP;
                3'd3:    mode_of = M_ABS;
                3'd5:    mode_of = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
                3'd7:    mode_of = (aaa == 3'd5) ? M_ABSY : M_ABSX;
                default: mode_of = M_IMP;
            endcase
        end else begin
            case (bbb)
                3'd0: begin
                    if (op == 8'h00)                     mode_of = M_BRK;
                    else if (op == 8'h20)                mode_of = M_JSR;
                    else if (op == 8'h40 || op == 8'h60) mode_of = M_PULL;
                    else                                 mode_of = M_IMM;
                end
                3'd1: mode_of = M_ZP;
                3'd2: begin
                    if (op == 8'h08 || op == 8'h48)      mode_of = M_PUSH;
                    else if (op == 8'h28 || op == 8'h68) mode_of = M_PULL;
                    else                                 mode_of = M_IMP;
                end
                3'd3:    mode_of = M_ABS;
                3'd4:    mode_of = M_REL;
                3'd5:    mode_of = M_ZPX;
                3'd7:    mode_of = M_ABSX;
                default: mode_of = M_IMP;
            endcase
        end
    endfunction

    // returns {status, accumulator}
    function automatic logic [15:0] do_add(input logic [7:0] a, input logic [7:0] v,
                                           input logic [7:0] p);
        logic [8:0]        bin;
        logic [7:0]        f;
        logic [4:0]        lo;
        logic [4:0]        lo6;
        logic [9:0]        hi;
        logic signed [9:0] s;
        logic [7:0]        res;
        bin = {1'b0, a} + {1'b0, v} + {8'd0, p[0]};
        f = p & 8'h3c;
        f[1] = (bin[7:0] == 8'h00);
        if (p[3]) begin
            lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, p[0]};
            lo6 = lo + 5'd6;
            if (lo >= 5'd10) lo = {1'b1, lo6[3:0]};
            hi = {2'b00, a[7:4], 4'h0} + {2'b00, v[7:4], 4'h0} + {5'd0, lo};
            s = $signed({{2{a[7]}}, a[7:4], 4'h0}) + $signed({{2{v[7]}}, v[7:4], 4'h0})
                + $signed({5'd0, lo});
            f[7] = hi[7];
            f[6] = (s < -10'sd128) || (s > 10'sd127);
            if (hi >= 10'h0a0) hi = hi + 10'h060;
            f[0] = (hi >= 10'h100);
            res = hi[7:0];
        end else begin
            f[7] = bin[7];
            f[0] = bin[8];
            f[6] = ~(a[7] ^ v[7]) & (a[7] ^ bin[7]);
            res = bin[7:0];
        end
        do_add = {f, res};
    endfunction

    function automatic logic [15:0] do_sub(input logic [7:0] a, input logic [7:0] v,
                                           input logic [7:0] p);
        logic [8:0]         bin;
        logic [7:0]         f;
        logic signed [5:0]  lo;
        logic [5:0]         lo26;
        logic signed [10:0] hi;
        logic [7:0]         res;
        bin = {1'b0, a} + {1'b0, ~v} + {8'd0, p[0]};
        f = p & 8'h3c;
        f[1] = (bin[7:0] == 8'h00);
        f[7] = bin[7];
        f[0] = bin[8];
        f[6] = (a[7] ^ v[7]) & (a[7] ^ bin[7]);
        res = bin[7:0];
        if (p[3]) begin
            lo = $signed({2'b00, a[3:0]}) - $signed({2'b00, v[3:0]})
                 + $signed({5'd0, p[0]}) - 6'sd1;
            lo26 = lo + 6'sd26;
            if (lo < 0) lo = $signed({2'b11, lo26[3:0]});
            hi = $signed({3'b000, a[7:4], 4'h0}) - $signed({3'b000, v[7:4], 4'h0})
                 + 11'(lo);
            if (hi < 0) hi = hi - 11'sd96;
            res = hi[7:0];
        end
        do_sub = {f, res};
    endfunction

    function automatic logic [7:0] do_cmp(input logic [7:0] p, input logic [7:0] r,
                                          input logic [7:0] v);
        logic [7:0] q;
        q = set_nz(p, r - v);
        q[0] = (r >= v);
        do_cmp = q;
    endfunction

    // Execute a non-store operation; r is what a read-modify-write stores
    function automatic t_alu apply_op(input logic [7:0] op, input logic [7:0] vin,
                                      input t_regs rg);
        t_alu       o;
        logic [7:0] v;
        logic [1:0] cc;
        logic [2:0] bbb;
        logic [2:0] aaa;
        logic       cin;
        logic [15:0] pa;
        cc  = op[1:0];
        bbb = op[4:2];
        aaa = op[7:5];
        o.rg = rg;
        o.r  = vin;
        v    = vin;
        cin  = rg.p[0];
        pa   = 16'd0;
        if (cc == 2'd1) begin
            case (aaa)
                3'd0: begin o.rg.a = rg.a | v; o.rg.p = set_nz(rg.p, o.rg.a); end
                3'd1: begin o.rg.a = rg.a & v; o.rg.p = set_nz(rg.p, o.rg.a); end
                3'd2: begin o.rg.a = rg.a ^ v; o.rg.p = set_nz(rg.p, o.rg.a); end
                3'd3: begin
                    pa = do_add(rg.a, v, rg.p);
                    o.rg.a = pa[7:0];
                    o.rg.p = pa[15:8];
                end
                3'd5: begin o.rg.a = v; o.rg.p = set_nz(rg.p, v); end
                3'd6: o.rg.p = do_cmp(rg.p, rg.a, v);
                3'd7: begin
                    pa = do_sub(rg.a, v, rg.p);
                    o.rg.a = pa[7:0];
                    o.rg.p = pa[15:8];
                end
                default: ;
            endcase
        end else if (cc == 2'd2) begin
            if (!aaa[2]) begin
                // shifts and rotates
                if (bbb == 3'd2) v = rg.a;
                if (aaa[1]) o.r = {aaa[0] & cin, v[7:1]};
                else        o.r = {v[6:0], aaa[0] & cin};
                o.rg.p = set_nz(rg.p, o.r);
                o.rg.p[0] = aaa[1] ? v[0] : v[7];
                if (bbb == 3'd2) o.rg.a = o.r;
            end else begin
                case (op)
                    8'h8a: begin o.rg.a = rg.x; o.rg.p = set_nz(rg.p, rg.x); end
                    8'h9a: o.rg.s = rg.x;
                    8'haa: begin o.rg.x = rg.a; o.rg.p = set_nz(rg.p, rg.a); end
                    8'hba: begin o.rg.x = rg.s; o.rg.p = set_nz(rg.p, rg.s); end
                    8'hca: begin o.rg.x = rg.x - 8'd1; o.rg.p = set_nz(rg.p, o.rg.x); end
                    8'hea: ;
                    default: begin
                        if (aaa == 3'd5) begin
                            o.rg.x = v;
                            o.rg.p = set_nz(rg.p, v);
                        end else if (aaa == 3'd6) begin
                            o.r = v - 8'd1;
                            o.rg.p = set_nz(rg.p, o.r);
                        end else if (aaa == 3'd7) begin
                            o.r = v + 8'd1;
                            o.rg.p = set_nz(rg.p, o.r);
                        end
                    end
                endcase
            end
        end else begin
            case (op)
                8'h88: begin o.rg.y = rg.y - 8'd1; o.rg.p = set_nz(rg.p, o.rg.y); end
                8'ha8: begin o.rg.y = rg.a; o.rg.p = set_nz(rg.p, rg.a); end
                8'hc8: begin o.rg.y = rg.y + 8'd1; o.rg.p = set_nz(rg.p, o.rg.y); end
                8'he8: begin o.rg.x = rg.x + 8'd1; o.rg.p = set_nz(rg.p, o.rg.x); end
                8'h18: o.rg.p[0] = 1'b0;
                8'h38: o.rg.p[0] = 1'b1;
                8'h58: o.rg.p[2] = 1'b0;
                8'h78: o.rg.p[2] = 1'b1;
                8'h98: begin o.rg.a = rg.y; o.rg.p = set_nz(rg.p, rg.y); end
                8'hb8: o.rg.p[6] = 1'b0;
                8'hd8: o.rg.p[3] = 1'b0;
                8'hf8: o.rg.p[3] = 1'b1;
                default: begin
                    case (aaa)
                        3'd1: o.rg.p = (rg.p & 8'h3d) | (v & 8'hc0)
                                       | (((rg.a & v) == 8'h00) ? 8'h02 : 8'h00);
                        3'd5: begin o.rg.y = v; o.rg.p = set_nz(rg.p, v); end
                        3'd6: o.rg.p = do_cmp(rg.p, rg.y, v);
                        3'd7: o.rg.p = do_cmp(rg.p, rg.x, v);
                        default: ;
                    endcase
                end
            endcase
        end
        apply_op = o;
    endfunction

    t_regs      r_regs, n_regs;
    t_phase     r_ph, n_ph;
    logic [7:0] r_op, n_op;
    logic [15:0] r_ea, n_ea;
    logic [7:0] r_ol, n_ol;

    always_comb begin
        t_regs       rg;
        t_alu        alu;
        t_mode       md;
        logic [2:0]  wcnt;
        t_acc [3:0]  wr;
        logic        has_rd;
        logic [15:0] rd_addr;
        logic        do_ar;
        logic        do_fetch;
        logic [15:0] t;
        logic [15:0] ret;
        logic        flag;
        logic [7:0]  d;
        logic [7:0]  pb;
        rg       = r_regs;
        n_ph     = r_ph;
        n_op     = r_op;
        n_ea     = r_ea;
        n_ol     = r_ol;
        wcnt     = 3'd0;
        wr       = '0;
        has_rd   = 1'b1;
        rd_addr  = 16'd0;
        do_ar    = 1'b0;
        do_fetch = 1'b0;
        t        = 16'd0;
        ret      = 16'd0;
        flag     = 1'b0;
        d        = i_read_data;
        md       = mode_of(r_op);
        alu      = '0;
        pb       = 8'd0;

        if (!i_operation) begin
            do_fetch = 1'b1;
        end else begin
            unique case (r_ph)
                PH_OPCODE: begin
                    n_op = d;
                    md = mode_of(d);
                    case (md)
                        M_NOP: do_fetch = 1'b1;
                        M_IMP: begin
                            alu = apply_op(d, rg.a, rg);
                            rg = alu.rg;
                            do_fetch = 1'b1;
                        end
                        M_PUSH: begin
                            pb = (d == 8'h08) ? (rg.p | 8'h30) : rg.a;
                            wr[wcnt[1:0]] = '{KIND_WRITE, {STACK_PAGE, rg.s}, pb};
                            wcnt = wcnt + 3'd1;
                            rg.s = rg.s - 8'd1;
                            do_fetch = 1'b1;
                        end
                        M_PULL: begin
                            rg.s = rg.s + 8'd1;
                            rd_addr = {STACK_PAGE, rg.s};
                            n_ph = PH_PULL1;
                        end
                        M_BRK: begin
                            ret = rg.pc + 16'd1;
                            wr[0] = '{KIND_WRITE, {STACK_PAGE, rg.s}, ret[15:8]};
                            wr[1] = '{KIND_WRITE, {STACK_PAGE, rg.s - 8'd1}, ret[7:0]};
                            wr[2] = '{KIND_WRITE, {STACK_PAGE, rg.s - 8'd2}, rg.p | 8'h30};
                            wcnt = 3'd3;
                            rg.s = rg.s - 8'd3;
                            rg.p[2] = 1'b1;
                            rd_addr = VEC_BRK_LO;
                            n_ph = PH_VECLO;
                        end
                        default: begin
                            rd_addr = rg.pc;
                            rg.pc = rg.pc + 16'd1;
                            n_ph = PH_OPLO;
                        end
                    endcase
                end
                PH_OPLO: begin
                    case (md)
                        M_IMM: begin
                            alu = apply_op(r_op, d, rg);
                            rg = alu.rg;
                            do_fetch = 1'b1;
                        end
                        M_REL: begin
                            case (r_op[7:6])
                                2'd0:    flag = rg.p[7];
                                2'd1:    flag = rg.p[6];
                                2'd2:    flag = rg.p[0];
                                default: flag = rg.p[1];
                            endcase
                            if (flag == r_op[5]) rg.pc = rg.pc + {{8{d[7]}}, d};
                            do_fetch = 1'b1;
                        end
                        M_ZP: begin n_ea = {8'd0, d}; do_ar = 1'b1; end
                        M_ZPX: begin n_ea = {8'd0, d + rg.x}; do_ar = 1'b1; end
                        M_ZPY: begin n_ea = {8'd0, d + rg.y}; do_ar = 1'b1; end
                        M_INDX: begin
                            n_ea = {8'd0, d + rg.x};
                            rd_addr = n_ea;
                            n_ph = PH_PTRLO;
                        end
                        M_INDY: begin
                            n_ea = {8'd0, d};
                            rd_addr = n_ea;
                            n_ph = PH_PTRLO;
                        end
                        default: begin
                            n_ol = d;
                            rd_addr = rg.pc;
                            rg.pc = rg.pc + 16'd1;
                            n_ph = PH_OPHI;
                        end
                    endcase
                end
                PH_OPHI: begin
                    t = {d, r_ol};
                    if (md == M_JSR) begin
                        ret = rg.pc - 16'd1;
                        wr[0] = '{KIND_WRITE, {STACK_PAGE, rg.s}, ret[15:8]};
                        wr[1] = '{KIND_WRITE, {STACK_PAGE, rg.s - 8'd1}, ret[7:0]};
                        wcnt = 3'd2;
                        rg.s = rg.s - 8'd2;
                        rg.pc = t;
                        do_fetch = 1'b1;
                    end else begin
                        if (md == M_ABSX) t = t + {8'd0, rg.x};
                        if (md == M_ABSY) t = t + {8'd0, rg.y};
                        n_ea = t;
                        do_ar = 1'b1;
                    end
                end
                PH_PTRLO: begin
                    n_ol = d;
                    rd_addr = {r_ea[15:8], r_ea[7:0] + 8'd1};
                    n_ph = PH_PTRHI;
                end
                PH_PTRHI: begin
                    t = {d, r_ol};
                    if (r_op == 8'h6c) begin
                        rg.pc = t;
                        do_fetch = 1'b1;
                    end else begin
                        if (md == M_INDY) t = t + {8'd0, rg.y};
                        n_ea = t;
                        do_ar = 1'b1;
                    end
                end
                PH_OPERAND: begin
                    alu = apply_op(r_op, d, rg);
                    rg = alu.rg;
                    if (r_op[1:0] == 2'd2 && r_op[7:5] != 3'd4 && r_op[7:5] != 3'd5) begin
                        wr[0] = '{KIND_WRITE, r_ea, alu.r};
                        wcnt = 3'd1;
                    end
                    do_fetch = 1'b1;
                end
                PH_PULL1: begin
                    if (r_op == 8'h68) begin
                        rg.a = d;
                        rg.p = set_nz(rg.p, d);
                        do_fetch = 1'b1;
                    end else if (r_op == 8'h28) begin
                        rg.p = d & 8'hcf;
                        do_fetch = 1'b1;
                    end else begin
                        if (r_op == 8'h40) rg.p = d & 8'hcf;
                        else               n_ol = d;
                        rg.s = rg.s + 8'd1;
                        rd_addr = {STACK_PAGE, rg.s};
                        n_ph = PH_PULL2;
                    end
                end
                PH_PULL2: begin
                    if (r_op == 8'h40) begin
                        n_ol = d;
                        rg.s = rg.s + 8'd1;
                        rd_addr = {STACK_PAGE, rg.s};
                        n_ph = PH_PULL3;
                    end else begin
                        rg.pc = {d, r_ol} + 16'd1;
                        do_fetch = 1'b1;
                    end
                end
                PH_PULL3, PH_VECHI: begin
                    rg.pc = {d, r_ol};
                    do_fetch = 1'b1;
                end
                PH_VECLO: begin
                    n_ol = d;
                    rd_addr = VEC_BRK_HI;
                    n_ph = PH_VECHI;
                end
                default: has_rd = 1'b0;   // data before start
            endcase
        end

        // effective address known: memory part of the instruction
        if (do_ar) begin
            if (r_op == 8'h4c) begin
                rg.pc = n_ea;
                do_fetch = 1'b1;
            end else if (r_op == 8'h6c) begin
                rd_addr = n_ea;
                n_ph = PH_PTRLO;
            end else if (r_op[7:5] == 3'd4) begin
                case (r_op[1:0])
                    2'd1:    pb = rg.a;
                    2'd2:    pb = rg.x;
                    default: pb = rg.y;
                endcase
                wr[0] = '{KIND_WRITE, n_ea, pb};
                wcnt = 3'd1;
                do_fetch = 1'b1;
            end else begin
                rd_addr = n_ea;
                n_ph = PH_OPERAND;
            end
        end

        if (do_fetch) begin
            rd_addr = rg.pc;
            rg.pc = rg.pc + 16'd1;
            n_ph = PH_OPCODE;
        end

        if (has_rd) wr[wcnt[1:0]] = '{KIND_READ, rd_addr, 8'd0};
        o_step.acc = wr;
        o_step.cnt = wcnt + {2'd0, has_rd};
        n_regs = rg;
    end

    assign o_regs = n_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '{a: 8'd0, x: 8'd0, y: 8'd0, p: 8'd0, s: SP_RESET, pc: 16'd0};
            r_ph   <= PH_WAIT;
            r_op   <= 8'd0;
            r_ea   <= 16'd0;
            r_ol   <= 8'd0;
        end else if (i_cfg_we) begin
            r_regs.pc <= i_cfg_wdata;
        end else if (i_take) begin
            r_regs <= n_regs;
            r_ph   <= n_ph;
            r_op   <= n_op;
            r_ea   <= n_ea;
            r_ol   <= n_ol;
        end
    end

endmodule

// ===== design/c65bs_obuf.sv =====
// Result buffer: holds the accesses of one request and sends them in order.
`timescale 1ns / 1ps
module c65bs_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  c65bs_pkg::t_step  i_step,
    input  c65bs_pkg::t_regs  i_regs,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output c65bs_pkg::t_acc   o_acc,
    output c65bs_pkg::t_regs  o_regs,
    output logic              o_last
);
    import c65bs_pkg::*;

    t_acc [3:0] r_buf;
    t_regs      r_regs;
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    // second slot: a request that arrives while the first one still drains
    t_acc [3:0] r_pbuf;
    t_regs      r_pregs;
    logic [2:0] r_pcnt;
    logic       r_pvalid;
    logic       take;
    logic       done;

    assign o_valid = (r_cnt != 3'd0);
    assign o_last  = ({1'b0, r_idx} == r_cnt - 3'd1);
    assign take    = o_valid && i_ready;
    // front slot is empty or its last access leaves at this edge
    assign done    = !o_valid || (take && o_last);
    assign o_free  = !r_pvalid;
    assign o_acc   = r_buf[r_idx];
    assign o_regs  = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 3'd0;
            r_idx    <= 2'd0;
            r_pvalid <= 1'b0;
        end else if (done) begin
            r_idx <= 2'd0;
            if (r_pvalid) begin
                r_cnt    <= r_pcnt;
                r_pvalid <= 1'b0;
            end else if (i_load) begin
                r_cnt <= i_step.cnt;
            end else begin
                r_cnt <= 3'd0;
            end
        end else begin
            if (take) r_idx <= r_idx + 2'd1;
            if (i_load) r_pvalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            if (r_pvalid) begin
                r_buf  <= r_pbuf;
                r_regs <= r_pregs;
            end else if (i_load) begin
                r_buf  <= i_step.acc;
                r_regs <= i_regs;
            end
        end else if (i_load) begin
            r_pbuf  <= i_step.acc;
            r_pregs <= i_regs;
            r_pcnt  <= i_step.cnt;
        end
    end

endmodule

// ===== design/cpu_8bit_6502_bus_stepper_top.sv =====
// Top level of the 6502 bus stepper.
//
//  port group   dir  tdata                                      tuser
//  s_axis       in   [7:0] read_data                            operation (0 start, 1 data)
//  m_axis       out  addr, wdata, a, x, y, p, sp, pc (see port) access_kind (0 rd, 1 wr)
//  cfg          in   start_pc, loads the program counter at once
//
// Each request is decoded and executed in the cycle it is accepted; its accesses
// (up to three writes, then one read, tlast on the read) go out one per cycle from
// the result buffer while m_axis_tready is high. A request that arrives while the
// previous one drains waits in a second slot; s_axis_tready is registered and high
// while that slot is empty, so one-access requests sustain one per clock, tready high.
// Synchronous reset: PC = 0, SP = 0xfd, core waits for a start request.
`timescale 1ns / 1ps
module cpu_8bit_6502_bus_stepper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] read_data
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] bus_address, [23:16] write_data, [31:24] acc_out, [39:32] x_out,
    // [47:40] y_out, [55:48] status_out, [63:56] stack_out, [79:64] pc_out
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser,   // access_kind
    output logic        m_axis_tlast    // last_access
);
    import c65bs_pkg::*;

    t_step step;
    t_regs regs;
    t_regs oregs;
    t_acc  acc;
    logic  take;
    logic  free;

    assign s_axis_tready = free;
    assign take = s_axis_tvalid && free;

    c65bs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_operation (s_axis_tuser),
        .i_read_data (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_step      (step),
        .o_regs      (regs)
    );

    c65bs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_step  (step),
        .i_regs  (regs),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_free  (free),
        .o_acc   (acc),
        .o_regs  (oregs),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = acc.kind;
    assign m_axis_tdata = {oregs.pc, oregs.s, oregs.p, oregs.y, oregs.x, oregs.a,
                           acc.data, acc.addr};

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the 6502 bus stepper: bus-level prediction with random stall.
`timescale 1ns / 1ps
module tb_top;
    import c65bs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        last;
        logic [7:0]  a, x, y, p, s;
        logic [15:0] pc;
    } t_bus_exp;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    cpu_8bit_6502_bus_stepper_top uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req     req_q[$];
    t_bus_exp bus_q[$];
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       mismatches = 0;
    int       cycles = 0;
    logic     s_fire = 1'b0;

    // predicted CPU state
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_p, cpu_s, cpu_op, cpu_latch;
    logic [15:0] cpu_pc, cpu_ea;
    t_phase      cpu_ph;
    logic        acc_kind[4];
    logic [15:0] acc_addr[4];
    logic [7:0]  acc_data[4];
    int          acc_cnt;

    function automatic bit is_documented(logic [7:0] op);
        logic [1:0] cc = op[1:0];
        logic [2:0] bbb = op[4:2];
        logic [2:0] aaa = op[7:5];
        if (cc == 2'd3) return 0;
        if (cc == 2'd1) return op != 8'h89;
        if (cc == 2'd2) begin
            case (bbb)
                3'd0: return op == 8'ha2;
                3'd4: return 0;
                3'd6: return op == 8'h9a || op == 8'hba;
                3'd7: return aaa != 3'd4;
                default: return 1;
            endcase
        end
        case (bbb)
            3'd0: return op != 8'h80;
            3'd1: return aaa == 3'd1 || aaa >= 3'd4;
            3'd3: return aaa >= 3'd1;
            3'd5: return aaa == 3'd4 || aaa == 3'd5;
            3'd7: return aaa == 3'd5;
            default: return 1;
        endcase
    endfunction

    function automatic t_mode mode_of(logic [7:0] op);
        logic [2:0] bbb = op[4:2];
        logic [2:0] aaa = op[7:5];
        if (!is_documented(op)) return M_NOP;
        if (op[1:0] == 2'd1) begin
            case (bbb)
                3'd0: return M_INDX;
                3'd1: return M_ZP;
                3'd2: return M_IMM;
                3'd3: return M_ABS;
                3'd4: return M_INDY;
                3'd5: return M_ZPX;
                3'd6: return M_ABSY;
                default: return M_ABSX;
            endcase
        end
        if (op[1:0] == 2'd2) begin
            case (bbb)
                3'd0: return M_IMM;
                3'd1: return M_ZP;
                3'd3: return M_ABS;
                3'd5: return (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
                3'd7: return aaa == 3'd5 ? M_ABSY : M_ABSX;
                default: return M_IMP;
            endcase
        end
        case (bbb)
            3'd0: begin
                if (op == 8'h00) return M_BRK;
                if (op == 8'h20) return M_JSR;
                if (op == 8'h40 || op == 8'h60) return M_PULL;
                return M_IMM;
            end
            3'd1: return M_ZP;
            3'd2: begin
                if (op == 8'h08 || op == 8'h48) return M_PUSH;
                if (op == 8'h28 || op == 8'h68) return M_PULL;
                return M_IMP;
            end
            3'd3: return M_ABS;
            3'd4: return M_REL;
            3'd5: return M_ZPX;
            3'd7: return M_ABSX;
            default: return M_IMP;
        endcase
    endfunction

    function automatic void set_nz(logic [7:0] v);
        cpu_p = (cpu_p & 8'h7d) | (v == 8'h00 ? 8'h02 : 8'h00) | (v & 8'h80);
    endfunction

    function automatic int sext(int v);
        return v >= 128 ? v - 256 : v;
    endfunction

    function automatic void add_acc(logic [7:0] vb);
        int a = cpu_a;
        int v = vb;
        int c = cpu_p[0];
        int bin = a + v + c;
        int lo, hi, sum;
        logic [7:0] f = cpu_p & 8'h3c;
        if (bin[7:0] == 8'h00) f[1] = 1'b1;
        if (cpu_p[3]) begin
            lo = (a & 15) + (v & 15) + c;
            if (lo >= 10) lo = ((lo + 6) & 15) + 16;
            hi = (a & 240) + (v & 240) + lo;
            sum = sext(a & 240) + sext(v & 240) + lo;
            if (hi & 128) f[7] = 1'b1;
            if (sum < -128 || sum > 127) f[6] = 1'b1;
            if (hi >= 160) hi += 96;
            if (hi >= 256) f[0] = 1'b1;
            cpu_a = hi[7:0];
        end else begin
            f[7] = bin[7];
            if (bin > 255) f[0] = 1'b1;
            if ((~(a ^ v)) & (a ^ bin) & 128) f[6] = 1'b1;
            cpu_a = bin[7:0];
        end
        cpu_p = f;
    endfunction

    function automatic void sub_acc(logic [7:0] vb);
        int a = cpu_a;
        int v = vb;
        int c = cpu_p[0];
        int bin = a + (v ^ 255) + c;
        int lo, hi;
        logic [7:0] f = cpu_p & 8'h3c;
        if (bin[7:0] == 8'h00) f[1] = 1'b1;
        f[7] = bin[7];
        if (bin > 255) f[0] = 1'b1;
        if ((a ^ v) & (a ^ bin) & 128) f[6] = 1'b1;
        if (cpu_p[3]) begin
            lo = (a & 15) - (v & 15) + c - 1;
            if (lo < 0) lo = ((lo + 26) & 15) - 16;
            hi = (a & 240) - (v & 240) + lo;
            if (hi < 0) hi -= 96;
            cpu_a = 8'((hi + 512) & 255);
        end else begin
            cpu_a = bin[7:0];
        end
        cpu_p = f;
    endfunction

    function automatic void compare(logic [7:0] r, logic [7:0] v);
        set_nz(r - v);
        cpu_p[0] = r >= v;
    endfunction

    // executes a non-store operation; returns the byte a read-modify-write stores
    function automatic logic [7:0] alu_op(logic [7:0] op, logic [7:0] v);
        logic [2:0] aaa = op[7:5];
        logic [7:0] r = v;
        logic cout;
        if (op[1:0] == 2'd1) begin
            case (aaa)
                3'd0: begin cpu_a |= v; set_nz(cpu_a); end
                3'd1: begin cpu_a &= v; set_nz(cpu_a); end
                3'd2: begin cpu_a ^= v; set_nz(cpu_a); end
                3'd3: add_acc(v);
                3'd5: begin cpu_a = v; set_nz(v); end
                3'd6: compare(cpu_a, v);
                3'd7: sub_acc(v);
                default: ;
            endcase
            return r;
        end
        if (op[1:0] == 2'd2) begin
            if (aaa < 3'd4) begin
                if (op[4:2] == 3'd2) v = cpu_a;
                cout = aaa[1] ? v[0] : v[7];
                if (aaa[1]) r = {aaa[0] & cpu_p[0], v[7:1]};
                else r = {v[6:0], aaa[0] & cpu_p[0]};
                set_nz(r);
                cpu_p[0] = cout;
                if (op[4:2] == 3'd2) cpu_a = r;
                return r;
            end
            case (op)
                8'h8a: begin cpu_a = cpu_x; set_nz(cpu_a); end
                8'h9a: cpu_s = cpu_x;
                8'haa: begin cpu_x = cpu_a; set_nz(cpu_x); end
                8'hba: begin cpu_x = cpu_s; set_nz(cpu_x); end
                8'hca: begin cpu_x--; set_nz(cpu_x); end
                8'hea: ;
                default: begin
                    if (aaa == 3'd5) begin cpu_x = v; set_nz(v); end
                    else if (aaa == 3'd6) begin r = v - 8'd1; set_nz(r); end
                    else if (aaa == 3'd7) begin r = v + 8'd1; set_nz(r); end
                end
            endcase
            return r;
        end
        case (op)
            8'h88: begin cpu_y--; set_nz(cpu_y); return r; end
            8'ha8: begin cpu_y = cpu_a; set_nz(cpu_y); return r; end
            8'hc8: begin cpu_y++; set_nz(cpu_y); return r; end
            8'he8: begin cpu_x++; set_nz(cpu_x); return r; end
            8'h18: begin cpu_p[0] = 1'b0; return r; end
            8'h38: begin cpu_p[0] = 1'b1; return r; end
            8'h58: begin cpu_p[2] = 1'b0; return r; end
            8'h78: begin cpu_p[2] = 1'b1; return r; end
            8'h98: begin cpu_a = cpu_y; set_nz(cpu_a); return r; end
            8'hb8: begin cpu_p[6] = 1'b0; return r; end
            8'hd8: begin cpu_p[3] = 1'b0; return r; end
            8'hf8: begin cpu_p[3] = 1'b1; return r; end
            default: ;
        endcase
        case (aaa)
            3'd1: cpu_p = (cpu_p & 8'h3d) | (v & 8'hc0) | ((cpu_a & v) == 8'h00 ? 8'h02 : 8'h00);
            3'd5: begin cpu_y = v; set_nz(v); end
            3'd6: compare(cpu_y, v);
            3'd7: compare(cpu_x, v);
            default: ;
        endcase
        return r;
    endfunction

    function automatic void bus_access(logic k, logic [15:0] a, logic [7:0] d);
        if (acc_cnt < 4) begin
            acc_kind[acc_cnt] = k;
            acc_addr[acc_cnt] = a;
            acc_data[acc_cnt] = d;
            acc_cnt++;
        end
    endfunction

    function automatic void read_at(logic [15:0] a, t_phase ph);
        bus_access(KIND_READ, a, 8'h00);
        cpu_ph = ph;
    endfunction

    function automatic void read_pc(t_phase ph);
        read_at(cpu_pc, ph);
        cpu_pc++;
    endfunction

    function automatic void push(logic [7:0] v);
        bus_access(KIND_WRITE, {STACK_PAGE, cpu_s}, v);
        cpu_s--;
    endfunction

    function automatic void pull(t_phase ph);
        cpu_s++;
        read_at({STACK_PAGE, cpu_s}, ph);
    endfunction

    function automatic void address_done();
        logic [7:0] op = cpu_op;
        if (op == 8'h4c) begin cpu_pc = cpu_ea; read_pc(PH_OPCODE); return; end
        if (op == 8'h6c) begin read_at(cpu_ea, PH_PTRLO); return; end
        if (op[7:5] == 3'd4) begin
            bus_access(KIND_WRITE, cpu_ea,
                       op[1:0] == 2'd1 ? cpu_a : (op[1:0] == 2'd2 ? cpu_x : cpu_y));
            read_pc(PH_OPCODE);
            return;
        end
        read_at(cpu_ea, PH_OPERAND);
    endfunction

    // runs one request through the predicted core and queues its accesses
    function automatic void predict_request(logic op, logic [7:0] d);
        logic [7:0]  r;
        logic [15:0] t;
        logic        flag;
        t_bus_exp    e;
        acc_cnt = 0;
        if (!op) begin
            read_pc(PH_OPCODE);
        end else begin
            case (cpu_ph)
                PH_OPCODE: begin
                    cpu_op = d;
                    case (mode_of(d))
                        M_NOP: read_pc(PH_OPCODE);
                        M_IMP: begin r = alu_op(d, cpu_a); read_pc(PH_OPCODE); end
                        M_PUSH: begin
                            push(d == 8'h08 ? (cpu_p | 8'h30) : cpu_a);
                            read_pc(PH_OPCODE);
                        end
                        M_PULL: pull(PH_PULL1);
                        M_BRK: begin
                            t = cpu_pc + 16'd1;
                            push(t[15:8]);
                            push(t[7:0]);
                            push(cpu_p | 8'h30);
                            cpu_p[2] = 1'b1;
                            read_at(VEC_BRK_LO, PH_VECLO);
                        end
                        default: read_pc(PH_OPLO);
                    endcase
                end
                PH_OPLO: begin
                    case (mode_of(cpu_op))
                        M_IMM: begin r = alu_op(cpu_op, d); read_pc(PH_OPCODE); end
                        M_REL: begin
                            case (cpu_op[7:6])
                                2'd0: flag = cpu_p[7];
                                2'd1: flag = cpu_p[6];
                                2'd2: flag = cpu_p[0];
                                default: flag = cpu_p[1];
                            endcase
                            if (flag == cpu_op[5]) cpu_pc = cpu_pc + {{8{d[7]}}, d};
                            read_pc(PH_OPCODE);
                        end
                        M_ZP: begin cpu_ea = {8'h00, d}; address_done(); end
                        M_ZPX: begin cpu_ea = {8'h00, d + cpu_x}; address_done(); end
                        M_ZPY: begin cpu_ea = {8'h00, d + cpu_y}; address_done(); end
                        M_INDX: begin
                            cpu_ea = {8'h00, d + cpu_x};
                            read_at(cpu_ea, PH_PTRLO);
                        end
                        M_INDY: begin cpu_ea = {8'h00, d}; read_at(cpu_ea, PH_PTRLO); end
                        default: begin cpu_latch = d; read_pc(PH_OPHI); end
                    endcase
                end
                PH_OPHI: begin
                    t = {d, cpu_latch};
                    case (mode_of(cpu_op))
                        M_JSR: begin
                            cpu_ea = cpu_pc - 16'd1;
                            push(cpu_ea[15:8]);
                            push(cpu_ea[7:0]);
                            cpu_pc = t;
                            read_pc(PH_OPCODE);
                        end
                        M_ABSX: begin cpu_ea = t + cpu_x; address_done(); end
                        M_ABSY: begin cpu_ea = t + cpu_y; address_done(); end
                        default: begin cpu_ea = t; address_done(); end
                    endcase
                end
                PH_PTRLO: begin
                    cpu_latch = d;
                    read_at({cpu_ea[15:8], cpu_ea[7:0] + 8'd1}, PH_PTRHI);
                end
                PH_PTRHI: begin
                    t = {d, cpu_latch};
                    if (cpu_op == 8'h6c) begin
                        cpu_pc = t;
                        read_pc(PH_OPCODE);
                    end else begin
                        if (mode_of(cpu_op) == M_INDY) t += cpu_y;
                        cpu_ea = t;
                        address_done();
                    end
                end
                PH_OPERAND: begin
                    r = alu_op(cpu_op, d);
                    if (cpu_op[1:0] == 2'd2 && cpu_op[7:5] != 3'd4 && cpu_op[7:5] != 3'd5)
                        bus_access(KIND_WRITE, cpu_ea, r);
                    read_pc(PH_OPCODE);
                end
                PH_PULL1: begin
                    if (cpu_op == 8'h68) begin
                        cpu_a = d; set_nz(d); read_pc(PH_OPCODE);
                    end else if (cpu_op == 8'h28) begin
                        cpu_p = d & 8'hcf; read_pc(PH_OPCODE);
                    end else if (cpu_op == 8'h40) begin
                        cpu_p = d & 8'hcf; pull(PH_PULL2);
                    end else begin
                        cpu_latch = d; pull(PH_PULL2);
                    end
                end
                PH_PULL2: begin
                    if (cpu_op == 8'h40) begin
                        cpu_latch = d; pull(PH_PULL3);
                    end else begin
                        cpu_pc = {d, cpu_latch} + 16'd1;
                        read_pc(PH_OPCODE);
                    end
                end
                PH_PULL3, PH_VECHI: begin
                    cpu_pc = {d, cpu_latch};
                    read_pc(PH_OPCODE);
                end
                PH_VECLO: begin cpu_latch = d; read_at(VEC_BRK_HI, PH_VECHI); end
                default: ;   // data before any start: no access
            endcase
        end
        for (int k = 0; k < acc_cnt; k++) begin
            e.kind = acc_kind[k];
            e.addr = acc_addr[k];
            e.wdata = acc_data[k];
            e.last = (k == acc_cnt - 1);
            e.a = cpu_a; e.x = cpu_x; e.y = cpu_y;
            e.p = cpu_p; e.s = cpu_s; e.pc = cpu_pc;
            bus_q.push_back(e);
        end
    endfunction

    function automatic void queue_req(logic op, logic [7:0] d);
        t_req q;
        q.op = op;
        q.data = d;
        req_q.push_back(q);
        predict_request(op, d);
    endfunction

    task automatic drain();
        while (req_q.size() != 0 || s_axis_tvalid || bus_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_start_pc(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cpu_pc = v;
    endtask

    // request driver
    always @(posedge i_clk) s_fire <= s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_fire)) begin
            if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= req_q[0].op;
                s_axis_tdata <= req_q[0].data;
                void'(req_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    // access monitor
    always @(posedge i_clk) begin
        t_bus_exp e;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            if (bus_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected access: kind %0d addr %h data %h",
                             m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16]);
            end else begin
                e = bus_q.pop_front();
                if (m_axis_tuser !== e.kind || m_axis_tlast !== e.last ||
                    m_axis_tdata !== {e.pc, e.s, e.p, e.y, e.x, e.a, e.wdata, e.addr}) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp k%0d l%0d %h  got k%0d l%0d %h",
                                 e.kind, e.last,
                                 {e.pc, e.s, e.p, e.y, e.x, e.a, e.wdata, e.addr},
                                 m_axis_tuser, m_axis_tlast, m_axis_tdata);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("** cpu_8bit_6502_bus_stepper_top: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [15:0] pc_set[4] = '{16'hffff, 16'h0000, 16'h0000, 16'hc000};
        int          pcts[4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{15, 15}};
        cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_p = 0; cpu_s = SP_RESET;
        cpu_pc = 0; cpu_op = 0; cpu_ph = PH_WAIT; cpu_ea = 0; cpu_latch = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // data before start is dropped
        queue_req(1'b1, 8'h5a);
        drain();
        write_start_pc(16'h80f0);
        queue_req(1'b0, 8'hff);
        // decimal add and subtract
        queue_req(1'b1, 8'hf8); queue_req(1'b1, 8'h69); queue_req(1'b1, 8'h99);
        queue_req(1'b1, 8'h38); queue_req(1'b1, 8'he9); queue_req(1'b1, 8'h0f);
        // BRK with vector
        queue_req(1'b1, 8'h00); queue_req(1'b1, 8'hfe); queue_req(1'b1, 8'h12);
        // JSR, then RTS
        queue_req(1'b1, 8'h20); queue_req(1'b1, 8'hff); queue_req(1'b1, 8'h34);
        queue_req(1'b1, 8'h60); queue_req(1'b1, 8'h00); queue_req(1'b1, 8'h80);
        // JMP indirect across page end
        queue_req(1'b1, 8'h6c); queue_req(1'b1, 8'hff); queue_req(1'b1, 8'h02);
        queue_req(1'b1, 8'h00); queue_req(1'b1, 8'h90);
        // PHP, undocumented, RTI, start mid-instruction
        queue_req(1'b1, 8'h08); queue_req(1'b1, 8'hff);
        queue_req(1'b1, 8'h40); queue_req(1'b1, 8'hff); queue_req(1'b0, 8'h00);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pcts[ph][0];
            stall_pct = pcts[ph][1];
            write_start_pc(ph == 2 ? 16'($urandom) : pc_set[ph]);
            queue_req(1'b0, 8'($urandom));
            for (int n = 0; n < 85; n++)
                queue_req($urandom_range(99) >= 3, 8'($urandom));
            drain();   // sender holds until all accesses are back
        end

        if (mismatches == 0)
            $display("** cpu_8bit_6502_bus_stepper_top: PASSED **");
        else
            $display("** cpu_8bit_6502_bus_stepper_top: FAILED **");
        $finish;
    end

endmodule
